// ===== src/stereo_atan_soft_saturator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo arctangent soft clipper
// Clocked, reset-qualified assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STEREO_ATAN_SOFT_SATURATOR_CORE_MACROS_SVH
`define STEREO_ATAN_SOFT_SATURATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Widths, constants and helper functions for the arctangent soft clipper.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ATAN_STEPS_REQ = 16;
    localparam int ATAN_STEPS = (ATAN_STEPS_REQ > 32) ? 32 : ATAN_STEPS_REQ;

    localparam int SAMPLE_FRAC = SAMPLE_BITS - 4;
    localparam int DRIVE_BITS = 16;
    localparam int DRIVE_FRAC = 12;
    localparam int ANGLE_FRAC = 30;

    // Product |x|*s carries SAMPLE_FRAC + DRIVE_FRAC fraction bits.
    localparam int PROD_W = SAMPLE_BITS + DRIVE_BITS;
    localparam int PROD_FRAC = SAMPLE_FRAC + DRIVE_FRAC;
    localparam int SH_R = (PROD_FRAC >= ANGLE_FRAC) ? PROD_FRAC - ANGLE_FRAC : 0;
    localparam int SH_L = (PROD_FRAC < ANGLE_FRAC) ? ANGLE_FRAC - PROD_FRAC : 0;
    localparam int DRIVE_SHIFT = ANGLE_FRAC - DRIVE_FRAC;

    // CORDIC vector and angle widths; arguments stay below 2^37.
    localparam int CW = 40;
    localparam int ZW = 33;
    localparam int STEP_W = 5;
    localparam int DEN_W = ZW - 1;

    // Divider: quotient bits SAMPLE_BITS down to 0, the top one flags overflow.
    localparam int QB = SAMPLE_BITS + 1;
    localparam int BIT_W = $clog2(QB);
    localparam int RW = SAMPLE_BITS + DEN_W + 1;

    localparam int IN_DATA_W = ((2 * SAMPLE_BITS + DRIVE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Pipeline: product, CORDIC steps, divider set-up, divider bits, output.
    localparam int NUM_STAGES = ATAN_STEPS + QB + 3;

    typedef struct packed {
        logic                   pass;
        logic                   neg_l;
        logic                   neg_r;
        logic [SAMPLE_BITS-1:0] raw_l;
        logic [SAMPLE_BITS-1:0] raw_r;
    } scp_side_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] e;
        case (i)
            5'd0:  e = 33'sd843314856;
            5'd1:  e = 33'sd497837829;
            5'd2:  e = 33'sd263043836;
            5'd3:  e = 33'sd133525158;
            5'd4:  e = 33'sd67021686;
            5'd5:  e = 33'sd33543515;
            5'd6:  e = 33'sd16775850;
            5'd7:  e = 33'sd8388437;
            5'd8:  e = 33'sd4194282;
            5'd9:  e = 33'sd2097149;
            5'd10: e = 33'sd1048575;
            5'd11: e = 33'sd524287;
            5'd12: e = 33'sd262143;
            5'd13: e = 33'sd131071;
            5'd14: e = 33'sd65535;
            5'd15: e = 33'sd32767;
            5'd16: e = 33'sd16383;
            5'd17: e = 33'sd8191;
            5'd18: e = 33'sd4095;
            5'd19: e = 33'sd2047;
            5'd20: e = 33'sd1023;
            5'd21: e = 33'sd511;
            5'd22: e = 33'sd255;
            5'd23: e = 33'sd127;
            5'd24: e = 33'sd63;
            5'd25: e = 33'sd31;
            5'd26: e = 33'sd15;
            5'd27: e = 33'sd7;
            5'd28: e = 33'sd3;
            5'd29: e = 33'sd1;
            default: e = '0;
        endcase
        return e;
    endfunction

    // Bring the Q.(F+12) product to Q.30; right shifts truncate.
    function automatic logic [CW-1:0] align_prod(input logic [PROD_W-1:0] p);
        logic [CW-1:0] a;
        a = CW'(p >> SH_R);
        return a << SH_L;
    endfunction

endpackage

// ===== src/scp_cordic_step.sv =====
// ----------------------------------------------------------------------------
// scp_cordic_step
// One registered vectoring-mode CORDIC iteration.
// ----------------------------------------------------------------------------
module scp_cordic_step (
    input  logic                            clk,
    input  logic                            en,
    input  logic [scp_pkg::STEP_W-1:0]      step,
    input  logic signed [scp_pkg::CW-1:0]   x_in,
    input  logic signed [scp_pkg::CW-1:0]   y_in,
    input  logic signed [scp_pkg::ZW-1:0]   z_in,
    output logic signed [scp_pkg::CW-1:0]   x_reg,
    output logic signed [scp_pkg::CW-1:0]   y_reg,
    output logic signed [scp_pkg::ZW-1:0]   z_reg
);

    logic signed [scp_pkg::CW-1:0] dx;
    logic signed [scp_pkg::CW-1:0] dy;
    logic signed [scp_pkg::CW-1:0] x_next;
    logic signed [scp_pkg::CW-1:0] y_next;
    logic signed [scp_pkg::ZW-1:0] z_next;

    // Arithmetic shifts give the floor of the scaled value.
    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        if (!y_in[scp_pkg::CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + scp_pkg::atan_entry(step);
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - scp_pkg::atan_entry(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ===== src/scp_div_step.sv =====
// ----------------------------------------------------------------------------
// scp_div_step
// One registered restoring-division step that settles one quotient bit.
// ----------------------------------------------------------------------------
module scp_div_step (
    input  logic                               clk,
    input  logic                               en,
    input  logic [scp_pkg::BIT_W-1:0]          bit_idx,
    input  logic [scp_pkg::RW-1:0]             rem_in,
    input  logic [scp_pkg::DEN_W-1:0]          den_in,
    input  logic [scp_pkg::QB-1:0]             q_in,
    output logic [scp_pkg::RW-1:0]             rem_reg,
    output logic [scp_pkg::DEN_W-1:0]          den_reg,
    output logic [scp_pkg::QB-1:0]             q_reg
);

    logic [scp_pkg::RW-1:0] trial;
    logic [scp_pkg::RW-1:0] rem_next;
    logic [scp_pkg::QB-1:0] q_next;

    always_comb
    begin
        trial    = scp_pkg::RW'(den_in) << bit_idx;
        rem_next = rem_in;
        q_next   = q_in;
        if (rem_in >= trial)
        begin
            rem_next        = rem_in - trial;
            q_next[bit_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

endmodule

// ===== src/stereo_atan_soft_saturator_core.sv =====
// ----------------------------------------------------------------------------
// stereo_atan_soft_saturator_core
// Stereo arctangent soft clipper: y = atan(x*s) / atan(s) on both channels.
// ----------------------------------------------------------------------------
// Usage: each transfer on the slave stream carries one stereo pair and its
// drive; each transfer on the master stream returns the shaped pair. Exactly
// one result follows every input transfer, in order.
// The datapath is a single pipeline of ATAN_STEPS + SAMPLE_BITS + 4 register
// stages (36 at the defaults): one for the magnitude product, one per CORDIC
// iteration (left, right and the drive normaliser run side by side), one to
// form the dividend, one per quotient bit of the restoring divider, and the
// output register. The first stage loads at the accepting edge, and m_tvalid
// rises once the item has passed every stage. Unless the receiver stalls,
// throughput is one stereo pair per clock cycle; the CORDIC and divider
// stages each retire one iteration per cycle for every item in flight.
// Reset clears the valid bits only, so the pipeline comes up empty and
// s_tready is high. When the receiver stalls with a result waiting, the whole
// pipeline holds: s_tready drops in the same cycle, nothing is lost or
// repeated, and work resumes as soon as m_tready returns.
// A drive of zero passes the samples through unchanged.
// ----------------------------------------------------------------------------
module stereo_atan_soft_saturator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // left_sample [15:0], right_sample [31:16], drive [47:32]
    input  logic [scp_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_result [15:0], right_result [31:16]
    output logic [scp_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int SB = scp_pkg::SAMPLE_BITS;
    localparam int NS = scp_pkg::NUM_STAGES;
    localparam int STEPS = scp_pkg::ATAN_STEPS;
    localparam int QB = scp_pkg::QB;

    // Global advance: every stage moves when the output is free or taken.
    logic adv;

    logic [NS-1:0]        valid_reg;
    scp_pkg::scp_side_t   side_reg [NS-1];

    // Input split and magnitude product.
    logic [SB-1:0]                    in_l;
    logic [SB-1:0]                    in_r;
    logic [scp_pkg::DRIVE_BITS-1:0]   drive;
    logic [SB-1:0]                    mag_l;
    logic [SB-1:0]                    mag_r;
    logic [scp_pkg::CW-1:0]           arg_l_reg;
    logic [scp_pkg::CW-1:0]           arg_r_reg;
    logic [scp_pkg::CW-1:0]           arg_d_reg;

    // CORDIC lanes: 0 left, 1 right, 2 drive normaliser.
    logic signed [scp_pkg::CW-1:0]    cx [STEPS+1][3];
    logic signed [scp_pkg::CW-1:0]    cy [STEPS+1][3];
    logic signed [scp_pkg::ZW-1:0]    cz [STEPS+1][3];

    // Divider lanes: 0 left, 1 right.
    logic [scp_pkg::RW-1:0]           rem_w [QB+1][2];
    logic [scp_pkg::DEN_W-1:0]        den_w [QB+1][2];
    logic [scp_pkg::QB-1:0]           q_w   [QB+1][2];
    logic [scp_pkg::RW-1:0]           rem_next [2];
    logic [scp_pkg::DEN_W-1:0]        den_next;

    logic [SB-1:0]                    res_next [2];
    logic [scp_pkg::OUT_DATA_W-1:0]   data_reg;

    assign adv      = !valid_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = data_reg;

    assign in_l  = s_tdata[SB-1:0];
    assign in_r  = s_tdata[2*SB-1:SB];
    assign drive = s_tdata[2*SB+scp_pkg::DRIVE_BITS-1:2*SB];
    assign mag_l = in_l[SB-1] ? (~in_l + 1'b1) : in_l;
    assign mag_r = in_r[SB-1] ? (~in_r + 1'b1) : in_r;

    // Valid bits are the only state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].pass  <= (drive == '0);
            side_reg[0].neg_l <= in_l[SB-1];
            side_reg[0].neg_r <= in_r[SB-1];
            side_reg[0].raw_l <= in_l;
            side_reg[0].raw_r <= in_r;
            for (int k = 1; k < NS - 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            arg_l_reg <= scp_pkg::align_prod(scp_pkg::PROD_W'(mag_l) *
                                             scp_pkg::PROD_W'(drive));
            arg_r_reg <= scp_pkg::align_prod(scp_pkg::PROD_W'(mag_r) *
                                             scp_pkg::PROD_W'(drive));
            arg_d_reg <= scp_pkg::CW'(drive) << scp_pkg::DRIVE_SHIFT;
        end
    end

    // CORDIC start vectors: x = 1.0, y = argument, z = 0.
    always_comb
    begin
        cx[0][0] = scp_pkg::CW'(1) << scp_pkg::ANGLE_FRAC;
        cx[0][1] = scp_pkg::CW'(1) << scp_pkg::ANGLE_FRAC;
        cx[0][2] = scp_pkg::CW'(1) << scp_pkg::ANGLE_FRAC;
        cy[0][0] = arg_l_reg;
        cy[0][1] = arg_r_reg;
        cy[0][2] = arg_d_reg;
        cz[0][0] = '0;
        cz[0][1] = '0;
        cz[0][2] = '0;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            scp_cordic_step u_step (
                .clk   (clk),
                .en    (adv),
                .step  (scp_pkg::STEP_W'(i)),
                .x_in  (cx[i][j]),
                .y_in  (cy[i][j]),
                .z_in  (cz[i][j]),
                .x_reg (cx[i+1][j]),
                .y_reg (cy[i+1][j]),
                .z_reg (cz[i+1][j])
            );
        end
    end

    // Negative angles count as zero in the numerator; the denominator is
    // held at one or more. The half-denominator term gives round half up.
    always_comb
    begin
        if (cz[STEPS][2][scp_pkg::ZW-1] || cz[STEPS][2] == '0)
        begin
            den_next = scp_pkg::DEN_W'(1);
        end
        else
        begin
            den_next = cz[STEPS][2][scp_pkg::DEN_W-1:0];
        end
        for (int j = 0; j < 2; j++)
        begin
            if (cz[STEPS][j][scp_pkg::ZW-1])
            begin
                rem_next[j] = scp_pkg::RW'(den_next >> 1);
            end
            else
            begin
                rem_next[j] = (scp_pkg::RW'(cz[STEPS][j][scp_pkg::DEN_W-1:0])
                               << scp_pkg::SAMPLE_FRAC) + scp_pkg::RW'(den_next >> 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                rem_w[0][j] <= rem_next[j];
                den_w[0][j] <= den_next;
                q_w[0][j]   <= '0;
            end
        end
    end

    // Quotient bits from SAMPLE_BITS down to 0; a set top bit means overflow.
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            scp_div_step u_step (
                .clk     (clk),
                .en      (adv),
                .bit_idx (scp_pkg::BIT_W'(QB - 1 - k)),
                .rem_in  (rem_w[k][j]),
                .den_in  (den_w[k][j]),
                .q_in    (q_w[k][j]),
                .rem_reg (rem_w[k+1][j]),
                .den_reg (den_w[k+1][j]),
                .q_reg   (q_w[k+1][j])
            );
        end
    end

    // Saturate the magnitude, restore the sign, or pass through at zero drive.
    always_comb
    begin
        logic [QB-1:0] limit;
        logic [QB-1:0] sat;
        logic          neg;
        logic [SB-1:0] raw;
        for (int j = 0; j < 2; j++)
        begin
            neg   = (j == 0) ? side_reg[NS-2].neg_l : side_reg[NS-2].neg_r;
            raw   = (j == 0) ? side_reg[NS-2].raw_l : side_reg[NS-2].raw_r;
            limit = (QB'(1) << (SB - 1)) - QB'(!neg);
            sat   = (q_w[QB][j] > limit) ? limit : q_w[QB][j];
            if (side_reg[NS-2].pass)
            begin
                res_next[j] = raw;
            end
            else if (neg)
            begin
                res_next[j] = ~sat[SB-1:0] + 1'b1;
            end
            else
            begin
                res_next[j] = sat[SB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= scp_pkg::OUT_DATA_W'({res_next[1], res_next[0]});
        end
    end

endmodule

// ===== src/scp_checker.sv =====
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the soft clipper's stream handshakes.
// ----------------------------------------------------------------------------
`include "stereo_atan_soft_saturator_core_macros.svh"

module scp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [scp_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [scp_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // A stalled result must stay put until it is taken.
    `SCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Back-pressure reaches the input in the same cycle as the stall.
    `SCP_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready, "input accepted during output stall")

    // With no result waiting, the pipeline is free to take a transfer.
    `SCP_ASSERT_NOW(a_empty_out_ready, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind stereo_atan_soft_saturator_core scp_checker u_scp_checker (.*);
